// ===== hw/rtl/lphm_pkg.sv =====
// ----------------------------------------------------------------------------
// lphm_pkg
// Shared sizes, hash constants, request codes and interface types of the
// linear probing hash map.
// ----------------------------------------------------------------------------
package lphm_pkg;

	localparam int INDEX_BITS = 10;
	localparam int SLOTS      = 1 << INDEX_BITS;
	localparam int KEY_W      = 32;
	localparam int VAL_W      = 8;
	localparam int WORD_W     = 1 + KEY_W + VAL_W;

	// The 64-bit mix multiplier, split into halves for 32x32 products.
	localparam logic [31:0] MIX_LO    = 32'hed558ccd;
	localparam logic [31:0] MIX_HI    = 32'hff51afd7;
	localparam int          MIX_SHIFT = 33;

	localparam logic MODE_LOOKUP = 1'b0;
	localparam logic MODE_STORE  = 1'b1;

	typedef logic [INDEX_BITS-1:0] index_t;

	typedef struct packed {
		logic             mode;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		index_t           home;
	} probe_req_t;

	typedef struct packed {
		logic             done;
		logic             hit;
		logic [VAL_W-1:0] read_value;
		logic             table_full;
	} probe_rsp_t;

endpackage

// ===== hw/rtl/linear_probe_hash_map.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_map
// Open-addressed hash map with linear probing over 32-bit keys and 8-bit
// values; each request is a lookup or a store and gives one result.
// ----------------------------------------------------------------------------
// Flow: an accepted request has its home slot hashed by the multiply
// pipeline, then the walk reads one slot at a time from the home slot,
// and the result moves to the output register once that can take it.
// Only one request is in flight at a time; the next is accepted only
// after the last result has moved into the output register. Reset: all
// 2**INDEX_BITS slots (1024 by default) are cleared, one slot per cycle; in_stall stays high during that pass.
// ----------------------------------------------------------------------------
module linear_probe_hash_map import lphm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// Request channel.
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             mode,
	input  logic [KEY_W-1:0] key,
	input  logic [VAL_W-1:0] value,
	// Result channel.
	output logic             out_valid,
	input  logic             out_stall,
	output logic             hit,
	output logic [VAL_W-1:0] read_value,
	output logic             table_full
);

	// A request is in flight from its acceptance until its result has been
	// moved into the output register. Only one is in flight at a time, so
	// the store write-back of one request always lands before the next
	// request's first slot read, and no forwarding is needed.
	logic             busy_q;
	logic             mode_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;

	logic             out_valid_q;
	logic             hit_q;
	logic [VAL_W-1:0] read_value_q;
	logic             full_q;

	logic       in_accept;
	logic       hash_done;
	index_t     hash_home;
	logic       clearing;
	probe_req_t preq;
	probe_rsp_t prsp;
	logic       take;

	// The request port closes during the clearing pass and while a request
	// is in flight. A finished result may still wait in the output register
	// when the next request is accepted.
	assign in_stall  = busy_q || clearing;
	assign in_accept = in_valid && !in_stall;

	// The result moves to the output register once that register is empty
	// or is being emptied in this cycle.
	assign take = prsp.done && (!out_valid_q || !out_stall);

	lphm_hash u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.start (in_accept),
		.key   (key),
		.done  (hash_done),
		.home  (hash_home)
	);

	always_comb begin
		preq.mode  = mode_q;
		preq.key   = key_q;
		preq.value = value_q;
		preq.home  = hash_home;
	end

	// The probe sequencer owns the slot memory; it starts as soon as the
	// home slot is known and holds its result until it is taken.
	lphm_probe u_probe (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (hash_done),
		.req     (preq),
		.take    (take),
		.clearing(clearing),
		.rsp     (prsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				busy_q <= 1'b1;
			end else if (take) begin
				busy_q <= 1'b0;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request and result payloads carry no reset.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_q  <= mode;
			key_q   <= key;
			value_q <= value;
		end
		if (take) begin
			hit_q        <= prsp.hit;
			read_value_q <= prsp.read_value;
			full_q       <= prsp.table_full;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;
	assign table_full = full_q;

endmodule

// ===== hw/rtl/lphm_ram.sv =====
// ----------------------------------------------------------------------------
// lphm_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module lphm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== hw/rtl/lphm_hash.sv =====
// ----------------------------------------------------------------------------
// lphm_hash
// Three-stage home slot hash: the 32x64 multiply is done as two 32x32
// partial products in successive stages, then folded and masked.
// ----------------------------------------------------------------------------
module lphm_hash import lphm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] key,
	output logic             done,
	output index_t           home
);

	logic        v_s1, v_s2, v_s3;
	logic [31:0] key_s1;
	logic [63:0] plo_s1, plo_s2;
	logic [31:0] phi_s2;
	index_t      home_s3;

	logic [31:0] sum_hi;
	logic [63:0] prod;

	// The key is zero-extended, so its own shift by 33 is zero and the mix
	// reduces to a plain multiply followed by the xor-shift.
	assign sum_hi = plo_s2[63:32] + phi_s2;
	assign prod   = {sum_hi, plo_s2[31:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_s1 <= key;
			plo_s1 <= 64'(key) * 64'(MIX_LO);
		end
		if (v_s1) begin
			plo_s2 <= plo_s1;
			phi_s2 <= 32'(64'(key_s1) * 64'(MIX_HI));
		end
		if (v_s2) begin
			home_s3 <= prod[INDEX_BITS-1:0] ^ prod[MIX_SHIFT +: INDEX_BITS];
		end
	end

	assign done = v_s3;
	assign home = home_s3;

endmodule

// ===== hw/rtl/lphm_probe.sv =====
// ----------------------------------------------------------------------------
// lphm_probe
// Slot table and probe sequencer: clears the table after reset, then walks
// slots from the home one read per cycle; a store writes a free or matching slot.
// ----------------------------------------------------------------------------
module lphm_probe import lphm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  probe_req_t req,
	input  logic       take,
	output logic       clearing,
	output probe_rsp_t rsp
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]       state_q;
	index_t           addr_q;
	index_t           cnt_q;
	probe_req_t       req_q;
	logic             hit_q;
	logic [VAL_W-1:0] read_value_q;
	logic             full_q;

	logic              wr_en;
	index_t            rd_addr;
	logic [WORD_W-1:0] wr_data;
	logic [WORD_W-1:0] rd_data;
	logic              slot_used;
	logic [KEY_W-1:0]  slot_key;
	logic [VAL_W-1:0]  slot_value;
	logic              is_empty;
	logic              is_match;
	logic              is_last;
	logic              finish;

	assign slot_used  = rd_data[WORD_W-1];
	assign slot_key   = rd_data[VAL_W +: KEY_W];
	assign slot_value = rd_data[VAL_W-1:0];

	assign is_empty = !slot_used;
	assign is_match = slot_used && (slot_key == req_q.key);
	assign is_last  = (cnt_q == '1);
	assign finish   = is_empty || is_match || is_last;

	// Reads run one slot ahead; the data of the slot at addr_q arrives
	// while the next one is being addressed.
	assign rd_addr = (state_q == ST_IDLE) ? req.home : index_t'(addr_q + 1'b1);

	always_comb begin
		wr_en   = 1'b0;
		wr_data = {1'b1, req_q.key, req_q.value};
		unique case (state_q) inside
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_data = '0;
			end
			ST_WALK: begin
				wr_en = (is_empty || is_match) && (req_q.mode == MODE_STORE);
			end
			ST_IDLE, ST_DONE: begin
				wr_en = 1'b0;
			end
		endcase
	end

	lphm_ram #(
		.WIDTH(WORD_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(addr_q),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			addr_q  <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					addr_q <= index_t'(addr_q + 1'b1);
					if (addr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						addr_q  <= req.home;
						cnt_q   <= '0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (finish) begin
						state_q <= ST_DONE;
					end else begin
						addr_q <= index_t'(addr_q + 1'b1);
						cnt_q  <= index_t'(cnt_q + 1'b1);
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			req_q <= req;
		end
		if (state_q == ST_WALK && finish) begin
			hit_q        <= is_match;
			read_value_q <= (is_match && req_q.mode == MODE_LOOKUP) ? slot_value : '0;
			full_q       <= !is_empty && !is_match;
		end
	end

	assign clearing       = (state_q == ST_CLEAR);
	assign rsp.done       = (state_q == ST_DONE);
	assign rsp.hit        = hit_q;
	assign rsp.read_value = read_value_q;
	assign rsp.table_full = full_q;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the linear probing hash map. Requests are queued
// ahead of time and driven onto the request channel with random gaps. Each
// accepted request is run through a private copy of the table to form the
// expected result. The monitor checks every result in order while it
// stalls the result channel at random.
// ----------------------------------------------------------------------------
module tb_top;
	import lphm_pkg::*;

	// One request as queued for the driver.
	typedef struct packed {
		logic             mode;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} map_req_t;

	// One expected result, with its request kept for error messages.
	typedef struct packed {
		logic             mode;
		logic [KEY_W-1:0] key;
		logic             hit;
		logic [VAL_W-1:0] read_value;
		logic             table_full;
	} map_rsp_t;

	localparam int IDLE_PCT     = 13;
	localparam int RANDOM_REQS  = 600;
	localparam int FULL_REQS    = 80;
	// Worst walk is a full sweep plus the hash and output stages.
	localparam int SETTLE_CYCLES = SLOTS + 64;

	logic             clk        = 1'b0;
	logic             arst_n     = 1'b0;
	logic             in_valid   = 1'b0;
	logic             mode       = MODE_LOOKUP;
	logic [KEY_W-1:0] key        = '0;
	logic [VAL_W-1:0] value      = '0;
	logic             out_stall  = 1'b0;
	logic             in_stall;
	logic             out_valid;
	logic             hit;
	logic [VAL_W-1:0] read_value;
	logic             table_full;

	linear_probe_hash_map dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.key        (key),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.read_value (read_value),
		.table_full (table_full)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The bench's own copy of the table. Only entries whose occupied bit is
	// set are ever read, so key and value entries need no reset.
	bit               occupied  [SLOTS];
	logic [KEY_W-1:0] slot_keys [SLOTS];
	logic [VAL_W-1:0] slot_vals [SLOTS];

	map_req_t pending_reqs[$];
	map_rsp_t expected_results[$];

	// Keys known to be in the table, and every key that the stimulus has
	// stored, drawn as fresh or marked, so that a fresh key is really absent.
	logic [KEY_W-1:0] live_keys[$];
	bit               key_seen[logic [KEY_W-1:0]];

	int n_accepted = 0;
	int n_stores   = 0;
	int n_lookups  = 0;
	int n_results  = 0;
	int n_hits     = 0;
	int n_full     = 0;
	int n_errors   = 0;

	// Neither side idles while this window of requests goes through, so the
	// block also sees a long back-to-back stretch.
	wire calm = (n_accepted >= 300) && (n_accepted < 420);

	// Home slot: the 64-bit finalizer mix of the zero-extended key, then the
	// low index bits.
	function automatic index_t mix_home(logic [KEY_W-1:0] k);
		logic [63:0] x;
		x = {32'd0, k};
		x = x ^ (x >> MIX_SHIFT);
		x = x * {MIX_HI, MIX_LO};
		x = x ^ (x >> MIX_SHIFT);
		return x[INDEX_BITS-1:0];
	endfunction

	// Walks the table copy from the home slot the way the block does and
	// applies a store. A sweep that meets neither the key nor a free slot
	// reports a full table and leaves the table as it was.
	function automatic map_rsp_t probe_table(map_req_t r);
		map_rsp_t res;
		index_t   s;
		res.mode       = r.mode;
		res.key        = r.key;
		res.hit        = 1'b0;
		res.read_value = '0;
		res.table_full = 1'b1;
		s = mix_home(r.key);
		for (int n = 0; n < SLOTS; n++) begin
			if (!occupied[s]) begin
				res.table_full = 1'b0;
				if (r.mode == MODE_STORE) begin
					occupied[s]  = 1'b1;
					slot_keys[s] = r.key;
					slot_vals[s] = r.value;
				end
				break;
			end
			if (slot_keys[s] == r.key) begin
				res.table_full = 1'b0;
				res.hit        = 1'b1;
				// A store answers with a zero value even when it updates.
				if (r.mode == MODE_STORE)
					slot_vals[s] = r.value;
				else
					res.read_value = slot_vals[s];
				break;
			end
			s = s + 1'b1;
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Request driver. A request stays on the ports until it is taken; a
	// new one is loaded only when the channel is free, unless this cycle
	// is picked as an idle one.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : request_driver
		logic     taken;
		map_req_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			taken = in_valid && !in_stall;
			if (taken) begin
				expected_results.push_back(probe_table('{mode, key, value}));
				n_accepted++;
				if (mode == MODE_STORE)
					n_stores++;
				else
					n_lookups++;
			end
			if (!in_valid || taken) begin
				if (pending_reqs.size() != 0 &&
				    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					nxt = pending_reqs.pop_front();
					mode     <= nxt.mode;
					key      <= nxt.key;
					value    <= nxt.value;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor. Every accepted result is compared with the oldest
	// expectation; the stall is redrawn each cycle whether or not a
	// result is waiting, so stalls land on every phase of a walk.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_monitor
		map_rsp_t exp_rsp;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (expected_results.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("ERROR: result with no request pending: hit=%0d read_value=%h table_full=%0d",
						         hit, read_value, table_full);
				end else begin
					exp_rsp = expected_results.pop_front();
					if (hit === 1'b1)
						n_hits++;
					if (table_full === 1'b1)
						n_full++;
					if (hit !== exp_rsp.hit || read_value !== exp_rsp.read_value ||
					    table_full !== exp_rsp.table_full) begin
						n_errors++;
						if (n_errors <= 10)
							$display({"ERROR: mode=%0d key=%h expected hit=%0d read_value=%h ",
							          "table_full=%0d, got hit=%0d read_value=%h table_full=%0d"},
							         exp_rsp.mode, exp_rsp.key, exp_rsp.hit,
							         exp_rsp.read_value, exp_rsp.table_full,
							         hit, read_value, table_full);
					end
				end
			end
			out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------
	function automatic void add_req(logic md, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
		pending_reqs.push_back('{md, k, v});
	endfunction

	// A random key that no earlier store or fresh key has used.
	function automatic logic [KEY_W-1:0] fresh_key();
		logic [KEY_W-1:0] k;
		do
			k = $urandom;
		while (key_seen.exists(k));
		key_seen[k] = 1'b1;
		return k;
	endfunction

	// Store of a key that is not yet in the table; it will take a slot.
	function automatic void add_new_store(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
		key_seen[k] = 1'b1;
		live_keys.push_back(k);
		add_req(MODE_STORE, k, v);
	endfunction

	function automatic logic [KEY_W-1:0] pick_live();
		return live_keys[$urandom_range(0, live_keys.size() - 1)];
	endfunction

	// Smallest key from a starting point whose home is the given slot.
	function automatic logic [KEY_W-1:0] find_key_for_slot(index_t target,
	                                                       logic [KEY_W-1:0] start);
		logic [KEY_W-1:0] k;
		k = start;
		while (mix_home(k) != target)
			k++;
		return k;
	endfunction

	// The pause between phases: the sender holds off until every request
	// has been taken and every expected result has come back.
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Stimulus. The table is never cleared after reset, so the phases
	// build on each other: a few directed requests, a random mix at
	// moderate load, a fill to capacity, then requests against the full
	// table.
	// ------------------------------------------------------------------
	initial begin : stimulus
		logic [KEY_W-1:0] w0, w1, w2, w3;
		int               pick;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Four keys whose home is the last slot, so their chain wraps to
		// the start of the table, where key zero already sits.
		w0 = find_key_for_slot(index_t'(SLOTS - 1), 32'd1);
		w1 = find_key_for_slot(index_t'(SLOTS - 1), w0 + 1);
		w2 = find_key_for_slot(index_t'(SLOTS - 1), w1 + 1);
		w3 = find_key_for_slot(index_t'(SLOTS - 1), w2 + 1);
		key_seen[w3] = 1'b1;

		// Directed part: lookup on an empty table, the extreme keys and
		// values, updates, a wrapped collision chain, and a miss that has
		// to walk the whole chain.
		add_req(MODE_LOOKUP, 32'h0000_0000, 8'hff);
		add_new_store(32'h0000_0000, 8'h00);
		add_new_store(32'hffff_ffff, 8'hff);
		add_req(MODE_LOOKUP, 32'h0000_0000, 8'h00);
		add_req(MODE_LOOKUP, 32'hffff_ffff, 8'h00);
		add_req(MODE_STORE, 32'hffff_ffff, 8'h5a);
		add_req(MODE_LOOKUP, 32'hffff_ffff, 8'hff);
		add_new_store(w0, 8'ha5);
		add_new_store(w1, 8'h3c);
		add_new_store(w2, 8'hc3);
		add_req(MODE_LOOKUP, w2, 8'h00);
		add_req(MODE_LOOKUP, w1, 8'h00);
		add_req(MODE_LOOKUP, w0, 8'h00);
		add_req(MODE_LOOKUP, w3, 8'h7e);
		add_req(MODE_STORE, w1, 8'h81);
		add_req(MODE_LOOKUP, w1, 8'h00);
		add_req(MODE_LOOKUP, 32'h8000_0000, 8'h01);
		add_req(MODE_STORE, 32'h0000_0000, 8'hff);
		add_req(MODE_LOOKUP, 32'h0000_0000, 8'h00);
		wait_drained();

		// Random mix: new keys, updates, lookups of present keys and
		// lookups that are most likely misses.
		for (int i = 0; i < RANDOM_REQS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				add_new_store(fresh_key(), $urandom_range(0, 255));
			else if (pick < 60)
				add_req(MODE_STORE, pick_live(), $urandom_range(0, 255));
			else if (pick < 90)
				add_req(MODE_LOOKUP, pick_live(), $urandom_range(0, 255));
			else
				add_req(MODE_LOOKUP, $urandom, $urandom_range(0, 255));
		end
		wait_drained();

		// Fill every remaining slot with new keys.
		while (live_keys.size() < SLOTS)
			add_new_store(fresh_key(), $urandom_range(0, 255));
		wait_drained();

		// Full table: present keys are still found and updated, absent
		// keys sweep the whole table and report it full.
		for (int i = 0; i < FULL_REQS; i++) begin
			case ($urandom_range(0, 3))
				0: add_req(MODE_LOOKUP, pick_live(), $urandom_range(0, 255));
				1: add_req(MODE_STORE, pick_live(), $urandom_range(0, 255));
				2: add_req(MODE_LOOKUP, fresh_key(), $urandom_range(0, 255));
				default: add_req(MODE_STORE, fresh_key(), $urandom_range(0, 255));
			endcase
		end
		wait_drained();

		// Let any stray result surface before the verdict.
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d requests (%0d stores, %0d lookups) and %0d results.",
		         n_accepted, n_stores, n_lookups, n_results);
		$display("Results had %0d hits and %0d full-table sweeps; %0d errors were found.",
		         n_hits, n_full, n_errors);
		if (n_errors == 0 && expected_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog, far beyond a run in which every request sweeps the table.
	initial begin : watchdog
		#100_000_000;
		$display("Timeout with %0d results still outstanding.", expected_results.size());
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/lphm_pkg.sv
hw/rtl/lphm_ram.sv
hw/rtl/lphm_hash.sv
hw/rtl/lphm_probe.sv
hw/rtl/linear_probe_hash_map.sv
verif/tb_top.sv
